// ----- rtl/dcd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Double click detector package
// Shared types and codes for the button single/double click detector.
// ----------------------------------------------------------------------------
package dcd_pkg;

  localparam int unsigned TimeW   = 32;
  localparam int unsigned CfgW    = 16;
  localparam int unsigned CfgIdxW = 2;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_WINDOW  = 2'd0,
    CFG_HOLDOFF = 2'd1
  } cfg_index_t;

  typedef enum logic [1:0] {
    EV_NEUTRAL = 2'd0,
    EV_SINGLE  = 2'd1,
    EV_DOUBLE  = 2'd2
  } click_event_t;

  typedef struct packed {
    logic [CfgW-1:0] window;
    logic [CfgW-1:0] holdoff;
  } cfg_t;

  typedef struct packed {
    logic was_pressed;
    logic pending_click;
    logic holdoff_active;
  } click_status_t;

endpackage

// ----- rtl/dcd_cfg_regs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Double click detector configuration registers
// Holds the click window and the double click holdoff time.
// ----------------------------------------------------------------------------
module dcd_cfg_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [dcd_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [dcd_pkg::CfgW-1:0]     cfg_data,
  output dcd_pkg::cfg_t                cfg
);
  import dcd_pkg::*;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.window  <= CfgW'(250);
      cfg.holdoff <= CfgW'(500);
    end else if (cfg_valid && cfg_ready) begin
      // Writes to unknown indexes are dropped.
      unique case (cfg_index_t'(cfg_index))
        CFG_WINDOW:  cfg.window  <= cfg_data;
        CFG_HOLDOFF: cfg.holdoff <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// ----- rtl/dcd_click_fsm.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Double click detector click tracker
// Keeps the press, pending click and holdoff state and classifies each sample.
// ----------------------------------------------------------------------------
module dcd_click_fsm (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        step,
  input  logic                        pin_level,
  input  logic [dcd_pkg::TimeW-1:0]   now_ms,
  input  dcd_pkg::cfg_t               cfg,
  output dcd_pkg::click_event_t       ev,
  output dcd_pkg::click_status_t      status
);
  import dcd_pkg::*;

  click_status_t     status_next;
  logic [TimeW-1:0]  release_stamp;
  logic [TimeW-1:0]  release_stamp_next;
  logic [TimeW-1:0]  double_stamp;
  logic [TimeW-1:0]  double_stamp_next;
  logic [TimeW-1:0]  since_release;
  logic [TimeW-1:0]  since_double;
  logic              pressed;
  logic              hold_live;

  always_comb begin
    pressed       = ~pin_level;
    since_release = now_ms - release_stamp;
    since_double  = now_ms - double_stamp;
    // Holdoff expiry is evaluated before the click decision of the same item.
    hold_live = status.holdoff_active &&
                !(since_double > {{(TimeW-CfgW){1'b0}}, cfg.holdoff});

    status_next        = status;
    status_next.holdoff_active = hold_live;
    release_stamp_next = release_stamp;
    double_stamp_next  = double_stamp;
    ev                 = EV_NEUTRAL;

    if (status.pending_click && !hold_live) begin
      if ((since_release > {{(TimeW-CfgW){1'b0}}, cfg.window}) && !pressed) begin
        status_next.was_pressed   = 1'b0;
        status_next.pending_click = 1'b0;
        ev                        = EV_SINGLE;
      end else if (pressed) begin
        status_next.was_pressed    = 1'b1;
        status_next.pending_click  = 1'b0;
        status_next.holdoff_active = 1'b1;
        double_stamp_next          = now_ms;
        ev                         = EV_DOUBLE;
      end else begin
        status_next.was_pressed = 1'b0;
      end
    end else begin
      if (pressed) begin
        status_next.was_pressed = 1'b1;
      end else begin
        status_next.pending_click = status.was_pressed;
        if (status.was_pressed) begin
          release_stamp_next = now_ms;
        end
        status_next.was_pressed = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      status        <= '0;
      release_stamp <= '0;
      double_stamp  <= '0;
    end else if (step) begin
      status        <= status_next;
      release_stamp <= release_stamp_next;
      double_stamp  <= double_stamp_next;
    end
  end

endmodule

// ----- rtl/double_click_detector.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Double click detector
// Classifies button samples as neutral, single push or double click.
// Flow: an accepted item waits in the input register until the output register
// is free or draining, then moves into it, where its result is presented.
// Throughput: one item per cycle while the output does not stall; the input
// register feeds the click tracker, whose state updates as each item moves on.
// Reset: synchronous; clears both pipeline stages and the click state and
// loads the window and holdoff registers with 250 and 500.
// ----------------------------------------------------------------------------
module double_click_detector (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        pin_level,
  input  logic [dcd_pkg::TimeW-1:0]   now_ms,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [1:0]                  click_event,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [dcd_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [dcd_pkg::CfgW-1:0]    cfg_data
);
  import dcd_pkg::*;

  cfg_t              cfg;
  click_event_t      ev;
  click_status_t     status;
  logic              s1_valid;
  logic              s1_pin;
  logic [TimeW-1:0]  s1_now;
  logic              advance;
  logic              accept;

  // The staged item moves on whenever the output register is free or draining.
  assign advance  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !advance;
  assign accept   = in_valid && !in_stall;

  dcd_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  dcd_click_fsm u_fsm (
    .clk       (clk),
    .rst       (rst),
    .step      (advance),
    .pin_level (s1_pin),
    .now_ms    (s1_now),
    .cfg       (cfg),
    .ev        (ev),
    .status    (status)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pin <= pin_level;
      s1_now <= now_ms;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      click_event <= ev;
    end
  end

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid && out_valid)
    else $error("input stalled while a stage was free");

  a_advance_fills_output: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("advanced item did not reach the output register");

  a_double_starts_holdoff: assert property (@(posedge clk) disable iff (rst)
    advance && ev == EV_DOUBLE |=> status.holdoff_active && !status.pending_click)
    else $error("double click did not start the holdoff");

  a_single_clears_pending: assert property (@(posedge clk) disable iff (rst)
    advance && ev == EV_SINGLE |=> !status.pending_click && !status.was_pressed)
    else $error("single push left a click pending");

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Double click detector testbench
// Drives timestamped button samples and register writes into the detector.
// A behavioral copy of the click tracker predicts one event per sample, and
// each event that comes out is compared with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;
  import dcd_pkg::*;

  localparam int IdleLimit = 1000;
  localparam logic [CfgIdxW-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_SPARE_B = 2'd3;
  localparam logic PIN_DOWN = 1'b0;
  localparam logic PIN_UP   = 1'b1;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               pin_level = PIN_UP;
  logic [TimeW-1:0]   now_ms = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [1:0]         click_event;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [CfgW-1:0]    cfg_data = '0;

  // Predicted tracker state and register copies.
  logic [CfgW-1:0]  window_ms = 16'd250;
  logic [CfgW-1:0]  holdoff_ms = 16'd500;
  logic             btn_down = 1'b0;
  logic             click_open = 1'b0;
  logic             holdoff_on = 1'b0;
  logic [TimeW-1:0] release_ms = '0;
  logic [TimeW-1:0] double_ms = '0;

  click_event_t     expected_events[$];
  int               mismatches = 0;
  int               idle_cycles = 0;
  int               stall_left = 0;
  bit               quiet = 1'b0;

  // Random gesture generator state.
  logic [TimeW-1:0] cursor_ms = '0;
  logic             gesture_level = PIN_UP;
  int               gesture_left = 0;

  double_click_detector u_top (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .pin_level   (pin_level),
    .now_ms      (now_ms),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .click_event (click_event),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic click_event_t classify_sample(input logic pin, input logic [TimeW-1:0] t);
    logic             pushed;
    logic [TimeW-1:0] since_release;
    logic [TimeW-1:0] since_double;
    click_event_t     ev;
    pushed        = (pin == PIN_DOWN);
    since_release = t - release_ms;
    since_double  = t - double_ms;
    ev            = EV_NEUTRAL;
    if (holdoff_on && since_double > {16'd0, holdoff_ms}) holdoff_on = 1'b0;
    if (click_open && !holdoff_on) begin
      if (since_release > {16'd0, window_ms} && !pushed) begin
        btn_down   = 1'b0;
        click_open = 1'b0;
        ev         = EV_SINGLE;
      end else if (pushed) begin
        btn_down   = 1'b1;
        click_open = 1'b0;
        holdoff_on = 1'b1;
        double_ms  = t;
        ev         = EV_DOUBLE;
      end else begin
        btn_down = 1'b0;
      end
    end else if (pushed) begin
      btn_down = 1'b1;
    end else begin
      // A release only opens a click when a press came before it.
      if (btn_down) begin
        click_open = 1'b1;
        release_ms = t;
      end else begin
        click_open = 1'b0;
      end
      btn_down = 1'b0;
    end
    return ev;
  endfunction

  task automatic send_sample(input logic pin, input logic [TimeW-1:0] t);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    pin_level <= pin;
    now_ms    <= t;
    do @(posedge clk); while (in_stall);
    expected_events.push_back(classify_sample(pin, t));
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_events.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_WINDOW:  window_ms = val;
      CFG_HOLDOFF: holdoff_ms = val;
      default: ;
    endcase
  endtask

  // Registers change only once every predicted event has come out.
  task automatic apply_config(input logic [CfgW-1:0] win, input logic [CfgW-1:0] hold,
                              input bit spare);
    drain_results();
    repeat (3) @(posedge clk);
    if (spare) begin
      write_reg(CFG_SPARE_A, 16'hFFFF);
      write_reg(CFG_SPARE_B, 16'h0001);
    end
    write_reg(CFG_WINDOW, win);
    write_reg(CFG_HOLDOFF, hold);
    cfg_valid <= 1'b0;
  endtask

  task automatic test_default_timing();
    send_sample(PIN_UP, 32'd0);
    send_sample(PIN_DOWN, 32'd10);
    send_sample(PIN_UP, 32'd20);
    send_sample(PIN_UP, 32'd270);   // exactly at the window edge: still neutral
    send_sample(PIN_UP, 32'd271);
    send_sample(PIN_DOWN, 32'd300);
    send_sample(PIN_UP, 32'd310);
    send_sample(PIN_DOWN, 32'd400);
    // This release opens a click inside the holdoff; it resolves once the holdoff ends.
    send_sample(PIN_UP, 32'd410);
    send_sample(PIN_UP, 32'd901);
  endtask

  task automatic test_register_extremes();
    apply_config(16'd0, 16'd0, 1'b1);
    send_sample(PIN_DOWN, 32'd1000);
    send_sample(PIN_UP, 32'd1000);
    send_sample(PIN_UP, 32'd1000);
    send_sample(PIN_UP, 32'd1001);
    send_sample(PIN_DOWN, 32'd2000);
    send_sample(PIN_UP, 32'd2001);
    send_sample(PIN_DOWN, 32'd2001);
    apply_config(16'hFFFF, 16'hFFFF, 1'b0);
    send_sample(PIN_UP, 32'd5000);
    send_sample(PIN_UP, 32'h0001_5000);
  endtask

  task automatic test_time_wrap();
    apply_config(16'd100, 16'd200, 1'b1);
    send_sample(PIN_DOWN, 32'hFFFF_FF00);
    send_sample(PIN_UP, 32'hFFFF_FFF0);
    send_sample(PIN_UP, 32'h0000_0060);
    send_sample(PIN_DOWN, 32'h0000_1000);
    send_sample(PIN_UP, 32'h0000_1010);
    // A step backwards in time reads as a very long elapsed time.
    send_sample(PIN_UP, 32'h0000_0F00);
    send_sample(PIN_DOWN, 32'hFFFF_FFFF);
  endtask

  task automatic send_gesture_sample();
    int          r;
    logic        pin;
    int unsigned step;
    r = $urandom_range(0, 99);
    if (r < 8) begin
      pin = 1'($urandom_range(0, 1));
    end else begin
      if (gesture_left == 0) begin
        gesture_level = ~gesture_level;
        gesture_left  = $urandom_range(1, 4);
      end
      gesture_left = gesture_left - 1;
      pin = gesture_level;
    end
    r = $urandom_range(0, 99);
    if (r < 55) step = $urandom_range(0, window_ms / 3 + 1);
    else if (r < 85) step = $urandom_range(0, 2 * window_ms + 2);
    else if (r < 97) step = $urandom_range(0, 2 * holdoff_ms + 2);
    else step = 0;
    if (r >= 97) cursor_ms = $urandom();
    else cursor_ms = cursor_ms + step;
    send_sample(pin, cursor_ms);
  endtask

  task automatic test_random_traffic();
    logic [CfgW-1:0] wins[5];
    logic [CfgW-1:0] holds[5];
    wins  = '{16'd250, 16'd0, 16'hFFFF, 16'd3, 16'd0};
    holds = '{16'd500, 16'd0, 16'hFFFF, 16'd7, 16'd0};
    wins[4]  = CfgW'($urandom());
    holds[4] = CfgW'($urandom());
    for (int p = 0; p < 5; p++) begin
      apply_config(wins[p], holds[p], p == 3);
      cursor_ms = $urandom();
      for (int i = 0; i < 285; i++) begin
        if (i % 50 == 0) quiet = (p == 2) || ($urandom_range(0, 3) == 0);
        send_gesture_sample();
      end
      quiet = 1'b0;
    end
  endtask

  // Receiver stalls come in runs, with open cycles between them.
  always @(posedge clk) begin : stall_gen
    if (stall_left == 0) stall_left = pick_gap();
    else stall_left = stall_left - 1;
    out_stall <= (stall_left != 0);
  end

  always @(posedge clk) begin : event_check
    click_event_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_events.size() == 0) begin
        $display("%0t: unexpected click_event, expected none, actual %0d", $time, click_event);
        mismatches++;
      end else begin
        want = expected_events.pop_front();
        if (click_event !== want) begin
          $display("%0t: click_event mismatch, expected %0d, actual %0d",
                   $time, want, click_event);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("%0t: no handshake for %0d cycles", $time, IdleLimit);
      $display("FAIL double_click_detector");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_default_timing();
    test_register_extremes();
    test_time_wrap();
    test_random_traffic();
    drain_results();
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS double_click_detector");
    end else begin
      $display("FAIL double_click_detector");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/dcd_pkg.sv
rtl/dcd_cfg_regs.sv
rtl/dcd_click_fsm.sv
rtl/double_click_detector.sv
tb/tb_top.sv
